[rtl/adc_to_timer_rate_interpolator_assert.svh]
// assertion helpers for the top-level rtl file
`ifndef ADC_TO_TIMER_RATE_INTERPOLATOR_ASSERT_SVH
`define ADC_TO_TIMER_RATE_INTERPOLATOR_ASSERT_SVH

// implication checked on every clock edge outside reset
`define ATI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("ati: implication check failed");

// plain condition checked on every clock edge outside reset
`define ATI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ati: invariant check failed");

`endif

[rtl/ati_pkg.sv]
`timescale 1ns / 1ps
package ati_pkg;

  localparam int TABLE_POINTS = 11;
  localparam int XW           = 12;
  localparam int PERW         = 16;
  localparam int DIVW         = 8;

  localparam logic [XW-1:0] BRK_X [TABLE_POINTS] = '{
    12'd0, 12'd408, 12'd817, 12'd1227, 12'd1637, 12'd2046,
    12'd2456, 12'd2866, 12'd3275, 12'd3685, 12'd4095
  };

  localparam logic [PERW-1:0] BRK_PERIOD [TABLE_POINTS] = '{
    16'd249, 16'd1694, 16'd847, 16'd564, 16'd423, 16'd338,
    16'd282, 16'd242, 16'd211, 16'd188, 16'd169
  };

  localparam logic [DIVW-1:0] PRE_ENDS [2] = '{8'd0, 8'd249};

  // largest quotient any segment can produce
  function automatic int max_quot();
    int m;
    int dy;
    m = int'(PRE_ENDS[1]) - int'(PRE_ENDS[0]);
    for (int i = 2; i < TABLE_POINTS; i++) begin
      dy = int'(BRK_PERIOD[i-1]) - int'(BRK_PERIOD[i]);
      if (dy > m) begin
        m = dy;
      end
    end
    return m;
  endfunction

  function automatic int period_min();
    int m;
    m = int'(BRK_PERIOD[1]);
    for (int i = 2; i < TABLE_POINTS; i++) begin
      if (int'(BRK_PERIOD[i]) < m) begin
        m = int'(BRK_PERIOD[i]);
      end
    end
    return m;
  endfunction

  function automatic int period_max();
    int m;
    m = int'(BRK_PERIOD[1]);
    for (int i = 2; i < TABLE_POINTS; i++) begin
      if (int'(BRK_PERIOD[i]) > m) begin
        m = int'(BRK_PERIOD[i]);
      end
    end
    return m;
  endfunction

  localparam int QW = $clog2(max_quot() + 1);
  localparam int PW = XW + QW;

  localparam logic [PERW-1:0] PERIOD_MIN = PERW'(period_min());
  localparam logic [PERW-1:0] PERIOD_MAX = PERW'(period_max());

  // one item travelling down the divider chain
  typedef struct packed {
    logic            valid;
    logic [PW-1:0]   rem;
    logic [PW-1:0]   dvs;
    logic [QW-1:0]   quo;
    logic [PERW-1:0] base;
    logic            is_pre;
  } lane_t;

endpackage

[rtl/ati_seg_sel.sv]
`timescale 1ns / 1ps
module ati_seg_sel (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [ati_pkg::XW-1:0] sample_i,
  output ati_pkg::lane_t      lane_o
);
  import ati_pkg::*;

  logic            a_valid_q;
  logic [XW-1:0]   a_n_d, a_n_q;
  logic [XW-1:0]   a_dx_d, a_dx_q;
  logic [QW-1:0]   a_dy_d, a_dy_q;
  logic [PERW-1:0] a_base_d, a_base_q;
  logic            a_pre_d, a_pre_q;

  logic            b_valid_q;
  logic [PW-1:0]   b_rem_d, b_rem_q;
  logic [PW-1:0]   b_dvs_d, b_dvs_q;
  logic [PERW-1:0] b_base_q;
  logic            b_pre_q;

  // segment lookup
  always_comb begin
    a_pre_d  = 1'b0;
    a_base_d = BRK_PERIOD[TABLE_POINTS-1];
    a_n_d    = '0;
    a_dx_d   = XW'(1);
    a_dy_d   = '0;
    if (sample_i <= BRK_X[1]) begin
      a_pre_d  = 1'b1;
      a_base_d = BRK_PERIOD[1];
      a_n_d    = BRK_X[1] - sample_i;
      a_dx_d   = BRK_X[1] - BRK_X[0];
      a_dy_d   = QW'(PRE_ENDS[1] - PRE_ENDS[0]);
    end else if (sample_i < BRK_X[TABLE_POINTS-1]) begin
      for (int i = TABLE_POINTS - 1; i >= 2; i--) begin
        if (sample_i < BRK_X[i]) begin
          a_base_d = BRK_PERIOD[i];
          a_n_d    = BRK_X[i] - sample_i;
          a_dx_d   = BRK_X[i] - BRK_X[i-1];
          a_dy_d   = QW'(BRK_PERIOD[i-1] - BRK_PERIOD[i]);
        end
      end
    end
    // zero-width segment gives its lower-end value
    if (a_dx_d == '0) begin
      a_n_d  = XW'(1);
      a_dx_d = XW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_n_q    <= a_n_d;
    a_dx_q   <= a_dx_d;
    a_dy_q   <= a_dy_d;
    a_base_q <= a_base_d;
    a_pre_q  <= a_pre_d;
  end

  // numerator product and aligned divisor
  assign b_rem_d = PW'(a_n_q) * PW'(a_dy_q);
  assign b_dvs_d = PW'(a_dx_q) << (QW - 1);

  always_ff @(posedge clk_i) begin
    b_rem_q  <= b_rem_d;
    b_dvs_q  <= b_dvs_d;
    b_base_q <= a_base_q;
    b_pre_q  <= a_pre_q;
  end

  assign lane_o.valid  = b_valid_q;
  assign lane_o.rem    = b_rem_q;
  assign lane_o.dvs    = b_dvs_q;
  assign lane_o.quo    = '0;
  assign lane_o.base   = b_base_q;
  assign lane_o.is_pre = b_pre_q;

endmodule

[rtl/ati_div_cell.sv]
`timescale 1ns / 1ps
module ati_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ati_pkg::lane_t lane_i,
  output ati_pkg::lane_t lane_o
);
  import ati_pkg::*;

  logic            valid_q;
  logic            ge;
  logic [PW-1:0]   rem_d, rem_q;
  logic [PW-1:0]   dvs_d, dvs_q;
  logic [QW-1:0]   quo_d, quo_q;
  logic [PERW-1:0] base_q;
  logic            pre_q;

  // one restoring quotient bit
  assign ge    = lane_i.rem >= lane_i.dvs;
  assign rem_d = ge ? lane_i.rem - lane_i.dvs : lane_i.rem;
  assign quo_d = {lane_i.quo[QW-2:0], ge};
  assign dvs_d = lane_i.dvs >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= lane_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    base_q <= lane_i.base;
    pre_q  <= lane_i.is_pre;
  end

  assign lane_o.valid  = valid_q;
  assign lane_o.rem    = rem_q;
  assign lane_o.dvs    = dvs_q;
  assign lane_o.quo    = quo_q;
  assign lane_o.base   = base_q;
  assign lane_o.is_pre = pre_q;

endmodule

[rtl/adc_to_timer_rate_interpolator.sv]
`timescale 1ns / 1ps
// Maps a 12-bit converter sample to a timer reload period and prescaler by
// piecewise-linear interpolation over a fixed breakpoint table. One item is
// taken per cycle whenever start_i is high; busy_o is always low. Every item
// gives one result on reload_period_o and clock_divider_o, marked by valid_o
// for exactly one cycle, after the item has passed the segment lookup,
// numerator multiply, one divider cell per quotient bit and output register.
// The receiver cannot stall, so results must be captured in the cycle valid_o
// is high.
`include "adc_to_timer_rate_interpolator_assert.svh"
module adc_to_timer_rate_interpolator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [ati_pkg::XW-1:0]    sample_i,
  output logic                      valid_o,
  output logic [ati_pkg::PERW-1:0]  reload_period_o,
  output logic [ati_pkg::DIVW-1:0]  clock_divider_o
);
  import ati_pkg::*;

  localparam int LAT = QW + 3;

  lane_t lane [QW+1];

  logic            valid_q;
  logic [PERW-1:0] period_d, period_q;
  logic [DIVW-1:0] divider_d, divider_q;

  ati_seg_sel u_seg_sel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .sample_i (sample_i),
    .lane_o   (lane[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_cell
    ati_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .lane_i (lane[k]),
      .lane_o (lane[k+1])
    );
  end

  always_comb begin
    if (lane[QW].is_pre) begin
      period_d  = lane[QW].base;
      divider_d = PRE_ENDS[0] + DIVW'(lane[QW].quo);
    end else begin
      period_d  = lane[QW].base + PERW'(lane[QW].quo);
      divider_d = PRE_ENDS[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= lane[QW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q  <= period_d;
    divider_q <= divider_d;
  end

  assign busy_o          = 1'b0;
  assign valid_o         = valid_q;
  assign reload_period_o = period_q;
  assign clock_divider_o = divider_q;

  `ATI_ASSERT_IMP(a_item_gives_result, start_i, ##LAT valid_o)
  `ATI_ASSERT_IMP(a_result_has_item, valid_o, $past(start_i, LAT))
  `ATI_ASSERT_IMP(a_prescale_only_low, valid_o && clock_divider_o != PRE_ENDS[0], reload_period_o == BRK_PERIOD[1])
  `ATI_ASSERT_ALWAYS(a_period_in_range, !valid_o || (reload_period_o >= PERIOD_MIN && reload_period_o <= PERIOD_MAX))

endmodule

[verif/tb_adc_to_timer_rate_interpolator.sv]
`timescale 1ns / 1ps
module tb_adc_to_timer_rate_interpolator;

  localparam int NUM_POINTS   = 11;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int STEADY_FIRST = 400;
  localparam int STEADY_LAST  = 700;

  localparam int SEG_X [NUM_POINTS] = '{
    0, 408, 817, 1227, 1637, 2046, 2456, 2866, 3275, 3685, 4095
  };
  localparam int SEG_PERIOD [NUM_POINTS] = '{
    249, 1694, 847, 564, 423, 338, 282, 242, 211, 188, 169
  };
  localparam int DIV_AT_ZERO = 249;

  typedef struct {
    logic [ati_pkg::XW-1:0]   smp;
    logic [ati_pkg::PERW-1:0] period;
    logic [ati_pkg::DIVW-1:0] divider;
  } timer_rate_t;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic [ati_pkg::XW-1:0]   sample_i = '0;
  logic                     valid_o;
  logic [ati_pkg::PERW-1:0] reload_period_o;
  logic [ati_pkg::DIVW-1:0] clock_divider_o;

  logic [ati_pkg::XW-1:0] pending_samples[$];
  timer_rate_t            expected_rates[$];
  int                     accepted_cnt = 0;
  int                     mismatch_cnt = 0;
  int                     cycle_cnt = 0;
  bit                     hold_off;

  adc_to_timer_rate_interpolator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .sample_i       (sample_i),
    .valid_o        (valid_o),
    .reload_period_o(reload_period_o),
    .clock_divider_o(clock_divider_o)
  );

  function automatic timer_rate_t predict_rate(input logic [ati_pkg::XW-1:0] smp);
    timer_rate_t r;
    int          v;
    int          per;
    int          dvd;
    v   = int'(smp);
    per = SEG_PERIOD[NUM_POINTS-1];
    dvd = 0;
    if (v <= SEG_X[1]) begin
      per = SEG_PERIOD[1];
      dvd = ((SEG_X[1] - v) * DIV_AT_ZERO) / (SEG_X[1] - SEG_X[0]);
    end else if (v < SEG_X[NUM_POINTS-1]) begin
      for (int k = 2; k < NUM_POINTS; k++) begin
        if (v < SEG_X[k]) begin
          per = SEG_PERIOD[k] + ((SEG_X[k] - v) * (SEG_PERIOD[k-1] - SEG_PERIOD[k]))
                / (SEG_X[k] - SEG_X[k-1]);
          break;
        end
      end
    end
    r.smp     = smp;
    r.period  = per[ati_pkg::PERW-1:0];
    r.divider = dvd[ati_pkg::DIVW-1:0];
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      sample_i <= '0;
    end else begin
      if (start_i && !busy_o) begin
        expected_rates.push_back(predict_rate(sample_i));
        accepted_cnt++;
      end
      if (!start_i || !busy_o) begin
        hold_off = (accepted_cnt < STEADY_FIRST || accepted_cnt >= STEADY_LAST) &&
                   ($urandom_range(99) < 38);
        if (pending_samples.size() > 0 && !hold_off) begin
          start_i  <= 1'b1;
          sample_i <= pending_samples.pop_front();
        end else begin
          start_i  <= 1'b0;
          sample_i <= ati_pkg::XW'($urandom);
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_rates.size() == 0) begin
        $display("%0t: unexpected result period=%0d divider=%0d", $time,
                 reload_period_o, clock_divider_o);
        mismatch_cnt++;
      end else begin
        timer_rate_t exp_r;
        exp_r = expected_rates.pop_front();
        if (reload_period_o !== exp_r.period) begin
          $display("%0t: sample %0d period expected %0d actual %0d", $time,
                   exp_r.smp, exp_r.period, reload_period_o);
          mismatch_cnt++;
        end
        if (clock_divider_o !== exp_r.divider) begin
          $display("%0t: sample %0d divider expected %0d actual %0d", $time,
                   exp_r.smp, exp_r.divider, clock_divider_o);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int sel;
    int pt;
    int v;
    // breakpoints, some of their neighbors, both ends and alternating bit patterns
    pending_samples = '{12'd0, 12'd1, 12'd2, 12'd407, 12'd408, 12'd409, 12'd816,
                        12'd817, 12'd1226, 12'd1227, 12'd1637, 12'd2046, 12'd2047,
                        12'd2456, 12'd2866, 12'd3275, 12'd3684, 12'd3685, 12'd4094,
                        12'd4095, 12'hAAA, 12'h555};
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        v = $urandom_range(4095);
      end else if (sel < 75) begin
        pt = $urandom_range(NUM_POINTS - 1);
        v  = SEG_X[pt] + $urandom_range(4) - 2;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end else begin
        v = $urandom_range(SEG_X[1]);
      end
      pending_samples.push_back(v[ati_pkg::XW-1:0]);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (pending_samples.size() != 0 || start_i || expected_rates.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ati_pkg.sv
rtl/ati_seg_sel.sv
rtl/ati_div_cell.sv
rtl/adc_to_timer_rate_interpolator.sv
verif/tb_adc_to_timer_rate_interpolator.sv
